FILE: rtl/core/itbd_pkg.sv
// Shared types, widths, character codes and the reciprocal table for the
// integer-to-text converter. No dependencies.
`default_nettype none

package itbd_pkg;

  localparam int ValueBits  = 32;
  localparam int CountW     = $clog2(ValueBits + 1);
  localparam int IdxW       = $clog2(ValueBits);
  localparam int BaseW      = 5;
  localparam int DigitW     = 4;
  localparam int CharW      = 7;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef logic [ValueBits-1:0] value_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    value_t           mag;
    logic [BaseW-1:0] base;
    logic             neg_dec;
  } item_t;

  localparam logic [BaseW-1:0] RadixReset = 5'd10;
  localparam logic [BaseW-1:0] BaseMin    = 5'd2;
  localparam logic [BaseW-1:0] BaseMax    = 5'd16;
  localparam logic [BaseW-1:0] BaseDec    = 5'd10;

  localparam logic [CharW-1:0] CharMinus  = 7'h2D;
  localparam logic [CharW-1:0] CharZero   = 7'h30;
  localparam logic [CharW-1:0] CharAlphaO = 7'h37;  // 'A' minus ten

  localparam logic [ValueBits:0] Pow = {1'b1, {ValueBits{1'b0}}};

  // Map a digit value to its upper-case ASCII character.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d < DigitW'(10)) digit_char = CharZero + dx;
    else digit_char = CharAlphaO + dx;
  endfunction

  // floor(2^ValueBits / base); the estimated quotient is then off by at most one.
  function automatic value_t recip(input logic [BaseW-1:0] b);
    case (b)
      5'd2:    recip = value_t'(Pow / 2);
      5'd3:    recip = value_t'(Pow / 3);
      5'd4:    recip = value_t'(Pow / 4);
      5'd5:    recip = value_t'(Pow / 5);
      5'd6:    recip = value_t'(Pow / 6);
      5'd7:    recip = value_t'(Pow / 7);
      5'd8:    recip = value_t'(Pow / 8);
      5'd9:    recip = value_t'(Pow / 9);
      5'd10:   recip = value_t'(Pow / 10);
      5'd11:   recip = value_t'(Pow / 11);
      5'd12:   recip = value_t'(Pow / 12);
      5'd13:   recip = value_t'(Pow / 13);
      5'd14:   recip = value_t'(Pow / 14);
      5'd15:   recip = value_t'(Pow / 15);
      default: recip = value_t'(Pow / 16);
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itbd_front.sv
// Front end: takes the input item, forms the magnitude and the effective base.
// Depends on itbd_pkg.
`default_nettype none

module itbd_front (
  input  wire logic [itbd_pkg::BaseW-1:0]     radix_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [itbd_pkg::ValueBits-1:0] number_i,
  output logic                                push_valid_o,
  input  wire logic                           push_ready_i,
  output itbd_pkg::item_t                     push_item_o
);

  logic                       neg;
  logic [itbd_pkg::BaseW-1:0] base;

  always_comb begin
    neg = number_i[itbd_pkg::ValueBits-1];
    if (radix_i < itbd_pkg::BaseMin) begin
      base = itbd_pkg::BaseMin;
    end else if (radix_i > itbd_pkg::BaseMax) begin
      base = itbd_pkg::BaseMax;
    end else begin
      base = radix_i;
    end
    // Two's complement negate keeps the most negative value exact as unsigned.
    push_item_o.mag     = neg ? (~number_i + itbd_pkg::ValueBits'(1)) : number_i;
    push_item_o.base    = base;
    push_item_o.neg_dec = neg && (base == itbd_pkg::BaseDec);
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

FILE: rtl/core/itbd_queue.sv
// Short item queue between front and back end.
// Depends on itbd_pkg.
`default_nettype none

module itbd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire itbd_pkg::item_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output itbd_pkg::item_t      pop_item_o
);

  itbd_pkg::item_t              mem_q [itbd_pkg::QueueDepth];
  logic [itbd_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [itbd_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [itbd_pkg::QPtrW:0]     count_q, count_d;
  logic                         push, pop;

  assign push_ready_o = (count_q != (itbd_pkg::QPtrW+1)'(itbd_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == itbd_pkg::QPtrW'(itbd_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + itbd_pkg::QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == itbd_pkg::QPtrW'(itbd_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + itbd_pkg::QPtrW'(1);
    end
    if (push && !pop) count_d = count_q + (itbd_pkg::QPtrW+1)'(1);
    else if (pop && !push) count_d = count_q - (itbd_pkg::QPtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

FILE: rtl/core/itbd_back.sv
// Back end: divides out digits one at a time and emits the characters.
// Depends on itbd_pkg.
`default_nettype none

module itbd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pop_valid_i,
  output logic                            pop_ready_o,
  input  wire itbd_pkg::item_t            pop_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [itbd_pkg::CharW-1:0]      character_o,
  output logic                            last_char_o
);

  localparam int VB = itbd_pkg::ValueBits;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StFix  = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;
  localparam logic [2:0] StZero = 3'd5;

  logic [2:0]                       state_q, state_d;
  itbd_pkg::value_t                 x_q, x_d;
  itbd_pkg::value_t                 recip_q, recip_d;
  itbd_pkg::value_t                 prod_q, prod_d;
  logic [itbd_pkg::BaseW-1:0]       base_q, base_d;
  logic                             neg_dec_q, neg_dec_d;
  logic [itbd_pkg::CountW-1:0]      cnt_q, cnt_d;
  logic [itbd_pkg::DigitW-1:0]      digit_q [VB];
  logic                             dig_we;
  logic [itbd_pkg::DigitW-1:0]      dig_wdata;
  logic                             out_valid_q, out_valid_d;
  logic [itbd_pkg::CharW-1:0]       char_q, char_d;
  logic                             last_q, last_d;

  logic [2*VB-1:0]                  full_prod;
  itbd_pkg::value_t                 qb, rem0, rem, quo;
  logic                             slot_free;
  logic [itbd_pkg::IdxW-1:0]        rd_idx;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == StIdle);
  assign rd_idx      = itbd_pkg::IdxW'(cnt_q - itbd_pkg::CountW'(1));

  assign full_prod = (2*VB)'(x_q) * (2*VB)'(recip_q);
  assign prod_d    = full_prod[2*VB-1:VB];

  // Estimated quotient is exact or one low: one compare-and-subtract fixes it.
  always_comb begin
    qb   = prod_q * VB'(base_q);
    rem0 = x_q - qb;
    if (rem0 >= VB'(base_q)) begin
      rem = rem0 - VB'(base_q);
      quo = prod_q + VB'(1);
    end else begin
      rem = rem0;
      quo = prod_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    recip_d     = recip_q;
    base_d      = base_q;
    neg_dec_d   = neg_dec_q;
    cnt_d       = cnt_q;
    dig_we      = 1'b0;
    dig_wdata   = rem[itbd_pkg::DigitW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          x_d       = pop_item_i.mag;
          base_d    = pop_item_i.base;
          recip_d   = itbd_pkg::recip(pop_item_i.base);
          neg_dec_d = pop_item_i.neg_dec;
          cnt_d     = '0;
          state_d   = (pop_item_i.mag == '0) ? StZero : StMul;
        end
      end
      StMul: begin
        state_d = StFix;
      end
      StFix: begin
        dig_we = 1'b1;
        cnt_d  = cnt_q + itbd_pkg::CountW'(1);
        x_d    = quo;
        if (quo != '0) state_d = StMul;
        else if (neg_dec_q) state_d = StSign;
        else state_d = StEmit;
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = itbd_pkg::CharMinus;
          last_d      = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = itbd_pkg::digit_char(digit_q[rd_idx]);
          last_d      = (cnt_q == itbd_pkg::CountW'(1));
          cnt_d       = cnt_q - itbd_pkg::CountW'(1);
          if (cnt_q == itbd_pkg::CountW'(1)) state_d = StIdle;
        end
      end
      StZero: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = itbd_pkg::CharZero;
          last_d      = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    recip_q   <= recip_d;
    prod_q    <= prod_d;
    base_q    <= base_d;
    neg_dec_q <= neg_dec_d;
    char_q    <= char_d;
    last_q    <= last_d;
    if (dig_we) digit_q[cnt_q[itbd_pkg::IdxW-1:0]] <= dig_wdata;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/int_to_base_digits.sv
// Top level of the integer-to-text converter: base register, front end,
// item queue and digit back end. Depends on itbd_pkg, itbd_front,
// itbd_queue and itbd_back.
//
// Each input item is a signed 32-bit integer; the block returns its text in
// the base held in the radix register (2 to 16; lower values act as 2, higher
// as 16), one ASCII character per output item, most significant digit first,
// upper-case A-F, last_char_o high on the final character. Zero gives "0";
// a negative value gives a leading '-' in base 10 and only the digits of its
// magnitude in any other base. The front end classifies the item and drops it
// into a two-entry queue, so up to two further items are taken while one is
// being converted. The back end finds each digit in a multiply state and a
// fix state: a 32x32 multiply by the base's reciprocal, then a small multiply,
// subtract and one-step correction. The back end takes no new item until the
// last character of the previous one is in its output register, and characters
// leave at one per cycle while the output is taken. Write the radix only while
// the block is idle.
`default_nettype none

module int_to_base_digits (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [itbd_pkg::BaseW-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [itbd_pkg::ValueBits-1:0] number_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [itbd_pkg::CharW-1:0]          character_o,
  output logic                                last_char_o
);

  logic [itbd_pkg::BaseW-1:0] radix_q, radix_d;
  logic                       push_valid, push_ready;
  itbd_pkg::item_t            push_item;
  logic                       pop_valid, pop_ready;
  itbd_pkg::item_t            pop_item;

  // Always take configuration writes.
  assign cfg_ready_o = 1'b1;
  assign radix_d     = cfg_valid_i ? cfg_data_i : radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itbd_pkg::RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  // Classify the item: magnitude, effective base, sign character needed.
  itbd_front u_front (
    .radix_i      (radix_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .number_i     (number_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Hold classified items until the back end is free.
  itbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Divide out the digits, then emit sign and digits through the output register.
  itbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_int_to_base_digits.sv
// Self-checking bench for int_to_base_digits: predicts the text of each integer
// in the current radix and compares every character and its last flag.
// Depends on itbd_pkg and the int_to_base_digits RTL.
`timescale 1ns / 100ps

module tb_int_to_base_digits;

  localparam int ResetCycles = 7;
  localparam int StallLimit  = 2000;  // cycles without any accepted item
  localparam int TailCycles  = 120;
  localparam int RandomPerPhase = 10;

  localparam logic [itbd_pkg::CharW-1:0] AsciiMinus = 7'h2D;
  localparam logic [itbd_pkg::CharW-1:0] AsciiZero  = 7'h30;
  localparam logic [itbd_pkg::CharW-1:0] AsciiUpperA = 7'h41;

  localparam itbd_pkg::value_t IntMin = 32'h8000_0000;
  localparam itbd_pkg::value_t IntMax = 32'h7FFF_FFFF;

  typedef struct {
    logic [itbd_pkg::CharW-1:0] code;
    logic                       last;
  } text_char_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [itbd_pkg::BaseW-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  itbd_pkg::value_t           number_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [itbd_pkg::CharW-1:0] character_o;
  logic                       last_char_o;

  itbd_pkg::value_t           pending_numbers[$];   // items waiting for the driver
  text_char_t                 expected_text[$];     // characters predicted, oldest first
  logic [itbd_pkg::BaseW-1:0] radix_model = itbd_pkg::RadixReset;
  int unsigned                mismatches = 0;

  int_to_base_digits uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append the expected text of one integer in the radix held by the model.
  function automatic void predict_text(input itbd_pkg::value_t value);
    itbd_pkg::value_t mag;
    itbd_pkg::value_t base;
    logic [3:0]       digits[$];
    logic [3:0]       d;
    text_char_t       ch;
    // magnitude of the minimum wraps to 2^31
    mag = value[itbd_pkg::ValueBits-1] ? -value : value;
    if (radix_model < itbd_pkg::BaseMin) base = itbd_pkg::value_t'(itbd_pkg::BaseMin);
    else if (radix_model > itbd_pkg::BaseMax) base = itbd_pkg::value_t'(itbd_pkg::BaseMax);
    else base = itbd_pkg::value_t'(radix_model);
    if (mag == '0) begin
      ch.code = AsciiZero;
      ch.last = 1'b1;
      expected_text.push_back(ch);
      return;
    end
    while (mag != '0) begin
      digits.push_front(4'(mag % base));
      mag = mag / base;
    end
    if (value[itbd_pkg::ValueBits-1] && base == itbd_pkg::value_t'(itbd_pkg::BaseDec)) begin
      ch.code = AsciiMinus;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    while (digits.size() != 0) begin
      d = digits.pop_front();
      ch.code = (d < 4'd10) ? AsciiZero + itbd_pkg::CharW'(d)
                            : AsciiUpperA + itbd_pkg::CharW'(d - 4'd10);
      ch.last = (digits.size() == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // Mix full-range words, small values, shifted words and values near the extremes.
  function automatic itbd_pkg::value_t random_number();
    itbd_pkg::value_t v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = $urandom_range(0, 40);
      2: v = $urandom() >> $urandom_range(1, 31);
      default: v = ($urandom_range(0, 1) != 0) ? IntMin + $urandom_range(0, 3)
                                                : IntMax - $urandom_range(0, 3);
    endcase
    if (($urandom_range(0, 1) != 0) && (v != IntMin)) v = -v;
    return v;
  endfunction

  // Block until the driver is empty and every predicted character has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_numbers.size() != 0 || in_valid_i || expected_text.size() != 0);
  endtask

  // Driver: issue pending items in bursts of random length, with random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      number_i   <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // predict on acceptance, with the radix in force right now
      if (in_valid_i && in_ready_o) predict_text(number_i);
      // hold valid and payload until the current item is taken
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
          in_valid_i <= 1'b1;
          number_i   <= pending_numbers.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 10);
            // one burst in three runs straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted character against the oldest prediction and
  // stall the output on a pattern that switches at random among four modes.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic        toggle = 1'b0;
  text_char_t  want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mode_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("character: expected none, got %h", character_o);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (character_o !== want.code) begin
            $error("character: expected %h, got %h", want.code, character_o);
            mismatches++;
          end
          if (last_char_o !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, last_char_o);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 60);
      end else begin
        mode_left = mode_left - 1;
      end
      toggle = ~toggle;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= toggle;
      endcase
    end
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequencer: reset, a directed pass in the reset radix, then phases that each
  // write the radix while idle and feed random items. The drain between phases
  // also makes the sender hold off until every character has come back.
  initial begin
    logic [itbd_pkg::BaseW-1:0] plan[11];
    logic [itbd_pkg::BaseW-1:0] next_radix;
    int unsigned                p;

    plan = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    for (p = 6; p < 11; p++) plan[p] = $urandom_range(0, 31);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset radix is decimal: zero, signs, extremes, alternating bit patterns
    pending_numbers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                        IntMax, IntMin, 32'd1_000_000_000, -32'sd999_999_999,
                        32'h5555_5555, 32'hAAAA_AAAA};
    wait_drained();

    for (p = 0; p < 11; p++) begin
      next_radix = plan[p];
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= next_radix;
      do @(posedge clk_i); while (!cfg_ready_o);
      radix_model = next_radix;
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= '0;

      // longest binary text, all hex letters, magnitude text of a negative value
      if (p == 0) pending_numbers = '{IntMin, IntMax, 32'hFFFF_FFFF, 32'd0};
      if (p == 1) pending_numbers = '{IntMin, IntMax, 32'h7EDC_BA98, 32'hFFFF_FFF0};
      repeat (RandomPerPhase) pending_numbers.push_back(random_number());
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/itbd_pkg.sv
rtl/core/itbd_front.sv
rtl/core/itbd_queue.sv
rtl/core/itbd_back.sv
rtl/core/int_to_base_digits.sv
bench/tb_int_to_base_digits.sv
